FILE: design/lcd4_pkg.sv
// Shared types, codes and constants for the 4-bit character LCD write sequencer.
package lcd4_pkg;

  // Configuration register widths and the config data bus width
  localparam int ENH_W = 12;
  localparam int CFG_W = 20;
  localparam int CFG_IDX_W = 2;

  // Defaults for the top-level parameter
  localparam int TIMER_BITS_DEF = 20;

  // Cursor address arithmetic
  localparam logic [7:0] CURSOR_BASE = 8'h80;
  localparam logic [7:0] ROW_OFFSET = 8'h40;

  // Fixed command bytes
  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [2:0] INIT_LAST_STEP = 3'd4;

  // Configuration reset values
  localparam logic [ENH_W-1:0] ENH_RESET = 12'd50;
  localparam logic [CFG_W-1:0] SETTLE_RESET = 20'd100000;
  localparam logic [CFG_W-1:0] EXTRA_RESET = 20'd100000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_EXTRA = 2'd2;

  // Request codes
  localparam logic [2:0] ACT_TICK = 3'd0;
  localparam logic [2:0] ACT_CMD = 3'd1;
  localparam logic [2:0] ACT_DATA = 3'd2;
  localparam logic [2:0] ACT_CURSOR = 3'd3;
  localparam logic [2:0] ACT_CLEAR = 3'd4;
  localparam logic [2:0] ACT_INIT = 3'd5;

  // Bus sequencing phases
  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_UP_HIGH = 6'b000010,
    PH_UP_LOW  = 6'b000100,
    PH_LO_HIGH = 6'b001000,
    PH_SETTLE  = 6'b010000,
    PH_EXTRA   = 6'b100000
  } phase_t;

  // One input transaction
  typedef struct packed {
    logic [2:0] action;
    logic [7:0] byte_value;
    logic       row;
    logic [3:0] column;
  } item_t;

  // One result transaction
  typedef struct packed {
    logic       rs_line;
    logic       enable_line;
    logic [3:0] data_nibble;
    logic       busy_res;
    logic       accepted;
  } res_t;

  // Timing configuration handed to the sequencer
  typedef struct packed {
    logic [ENH_W-1:0] enable_high_ticks;
    logic [CFG_W-1:0] settle_ticks;
    logic [CFG_W-1:0] clear_extra_ticks;
  } cfg_t;

  // Power-up init command sequence, step 0 first
  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'h33;
      3'd1: b = 8'h32;
      3'd2: b = 8'h28;
      3'd3: b = 8'h0C;
      3'd4: b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: design/lcd4_in_reg.sv
// Input register stage: holds one transaction until the sequencer takes it.
module lcd4_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  lcd4_pkg::item_t item_in,
  input  logic           take,
  output logic           q_valid,
  output lcd4_pkg::item_t q_item
);
  import lcd4_pkg::*;

  // Full and not draining this cycle: hold off the sender
  assign in_stall = q_valid && !take;

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!in_stall) begin
      q_valid <= in_valid;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      q_item <= item_in;
    end
  end

endmodule

FILE: design/lcd4_seq.sv
// Write sequencer state: phase, held byte, timer and init step, one update per tick.
module lcd4_seq #(
  parameter int TIMER_BITS = lcd4_pkg::TIMER_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  lcd4_pkg::item_t item,
  input  lcd4_pkg::cfg_t  cfg,
  output lcd4_pkg::res_t  res_next
);
  import lcd4_pkg::*;

  localparam longint unsigned TimerMax = (64'd1 << TIMER_BITS) - 64'd1;

  // Ticks to a down-count: zero counts as one, saturate at the timer's top
  function automatic logic [TIMER_BITS-1:0] load_count(input logic [CFG_W-1:0] ticks);
    logic [CFG_W-1:0] d;
    logic             sat;
    d = (ticks == '0) ? '0 : ticks - CFG_W'(1);
    sat = (64'(d) > TimerMax);
    return sat ? TIMER_BITS'(TimerMax) : TIMER_BITS'(d);
  endfunction

  phase_t                phase, phase_next;
  logic [7:0]            held_byte, held_byte_next;
  logic                  held_rs, held_rs_next;
  logic [TIMER_BITS-1:0] wait_timer, wait_timer_next;
  logic [2:0]            init_step, init_step_next;
  logic                  extra_pend, extra_pend_next;
  logic                  enable_reg, enable_reg_next;
  logic [3:0]            nibble_reg, nibble_reg_next;

  logic                  acc;
  logic                  do_start;
  logic                  do_end;
  logic [7:0]            sb;
  logic                  srs;
  logic                  sx;

  // Next-state logic for one tick
  always_comb begin
    phase_next = phase;
    held_byte_next = held_byte;
    held_rs_next = held_rs;
    wait_timer_next = wait_timer;
    init_step_next = init_step;
    extra_pend_next = extra_pend;
    enable_reg_next = enable_reg;
    nibble_reg_next = nibble_reg;
    acc = 1'b0;
    do_start = 1'b0;
    do_end = 1'b0;
    sb = '0;
    srs = 1'b0;
    sx = 1'b0;

    if (phase == PH_IDLE) begin
      // Request decode, only while idle
      acc = 1'b1;
      case (item.action)
        ACT_CMD: begin
          do_start = 1'b1;
          sb = item.byte_value;
        end
        ACT_DATA: begin
          do_start = 1'b1;
          sb = item.byte_value;
          srs = 1'b1;
        end
        ACT_CURSOR: begin
          do_start = 1'b1;
          sb = CURSOR_BASE + (item.row ? ROW_OFFSET : 8'h00) + {4'h0, item.column};
        end
        ACT_CLEAR: begin
          do_start = 1'b1;
          sb = CMD_CLEAR;
          sx = 1'b1;
        end
        ACT_INIT: begin
          do_start = 1'b1;
          sb = init_byte(3'd0);
          init_step_next = 3'd1;
        end
        default: acc = 1'b0;
      endcase
    end else if (wait_timer != '0) begin
      wait_timer_next = wait_timer - TIMER_BITS'(1);
    end else begin
      // Timer expired: move to the next phase
      case (phase)
        PH_UP_HIGH: begin
          enable_reg_next = 1'b0;
          phase_next = PH_UP_LOW;
          wait_timer_next = '0;
        end
        PH_UP_LOW: begin
          nibble_reg_next = held_byte[3:0];
          enable_reg_next = 1'b1;
          phase_next = PH_LO_HIGH;
          wait_timer_next = load_count(CFG_W'(cfg.enable_high_ticks));
        end
        PH_LO_HIGH: begin
          enable_reg_next = 1'b0;
          phase_next = PH_SETTLE;
          wait_timer_next = load_count(cfg.settle_ticks);
        end
        PH_SETTLE: begin
          if (extra_pend && cfg.clear_extra_ticks != '0) begin
            extra_pend_next = 1'b0;
            phase_next = PH_EXTRA;
            wait_timer_next = load_count(cfg.clear_extra_ticks);
          end else begin
            do_end = 1'b1;
          end
        end
        default: do_end = 1'b1;
      endcase
    end

    // Byte done: chain the next init byte or go idle
    if (do_end) begin
      extra_pend_next = 1'b0;
      if (init_step >= 3'd1 && init_step <= INIT_LAST_STEP) begin
        init_step_next = init_step + 3'd1;
        do_start = 1'b1;
        sb = init_byte(init_step);
        sx = (init_step == INIT_LAST_STEP);
      end else begin
        init_step_next = 3'd0;
        phase_next = PH_IDLE;
        wait_timer_next = '0;
      end
    end

    // Byte start: upper nibble out with enable high
    if (do_start) begin
      held_byte_next = sb;
      held_rs_next = srs;
      nibble_reg_next = sb[7:4];
      enable_reg_next = 1'b1;
      phase_next = PH_UP_HIGH;
      wait_timer_next = load_count(CFG_W'(cfg.enable_high_ticks));
      extra_pend_next = sx;
    end
  end

  // Pin levels after this tick's update
  always_comb begin
    res_next.rs_line = held_rs_next;
    res_next.enable_line = enable_reg_next;
    res_next.data_nibble = nibble_reg_next;
    res_next.busy_res = (phase_next != PH_IDLE);
    res_next.accepted = acc;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      held_byte <= '0;
      held_rs <= 1'b0;
      wait_timer <= '0;
      init_step <= '0;
      extra_pend <= 1'b0;
      enable_reg <= 1'b0;
      nibble_reg <= '0;
    end else if (step) begin
      phase <= phase_next;
      held_byte <= held_byte_next;
      held_rs <= held_rs_next;
      wait_timer <= wait_timer_next;
      init_step <= init_step_next;
      extra_pend <= extra_pend_next;
      enable_reg <= enable_reg_next;
      nibble_reg <= nibble_reg_next;
    end
  end

endmodule

FILE: design/char_lcd_4bit_write_sequencer_core.sv
// Top level: config registers, input stage, sequencer and result register.
//
//   channel | signals                                    | direction
//   --------+--------------------------------------------+----------
//   input   | in_valid, in_stall, action, byte_value,    | in
//           | row, column                                |
//   result  | out_valid, out_stall, rs_line, enable_line,| out
//           | data_nibble, busy_res, accepted            |
//   config  | cfg_we, cfg_index, cfg_data                | in
//
// Every input transaction is one LCD clock tick and yields one result.
// A transaction is held in the input register and is then applied to the sequencer state
// and written to the result register; one transaction per cycle unless the result stalls.
// Synchronous reset returns the sequencer to idle and empties both stages.
// A stalled result register holds the input stage, which then stalls the sender.
module char_lcd_4bit_write_sequencer_core #(
  parameter int TIMER_BITS = lcd4_pkg::TIMER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     action,
  input  logic [7:0]                     byte_value,
  input  logic                           row,
  input  logic [3:0]                     column,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           rs_line,
  output logic                           enable_line,
  output logic [3:0]                     data_nibble,
  output logic                           busy_res,
  output logic                           accepted,
  input  logic                           cfg_we,
  input  logic [lcd4_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lcd4_pkg::CFG_W-1:0]     cfg_data
);
  import lcd4_pkg::*;

  cfg_t  cfg;
  item_t item_in;
  item_t q_item;
  logic  q_valid;
  logic  take;
  res_t  res_next;
  res_t  res_q;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable_high_ticks <= ENH_RESET;
      cfg.settle_ticks <= SETTLE_RESET;
      cfg.clear_extra_ticks <= EXTRA_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE_HIGH: cfg.enable_high_ticks <= cfg_data[ENH_W-1:0];
        REG_SETTLE:      cfg.settle_ticks <= cfg_data;
        REG_CLEAR_EXTRA: cfg.clear_extra_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  assign item_in = '{action: action, byte_value: byte_value, row: row, column: column};

  lcd4_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .item_in  (item_in),
    .take     (take),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  // Process when the result register is empty or draining
  assign take = q_valid && (!out_valid || !out_stall);

  lcd4_seq #(
    .TIMER_BITS (TIMER_BITS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .step     (take),
    .item     (q_item),
    .cfg      (cfg),
    .res_next (res_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_q <= res_next;
    end
  end

  assign rs_line = res_q.rs_line;
  assign enable_line = res_q.enable_line;
  assign data_nibble = res_q.data_nibble;
  assign busy_res = res_q.busy_res;
  assign accepted = res_q.accepted;

  // A taken request always starts a byte
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> busy_res)
    else $error("request taken but sequencer not busy");

  // Enable is never high while idle
  a_enable_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && enable_line |-> busy_res)
    else $error("enable high while idle");

  // Input stalls only when its register is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_valid)
    else $error("input stalled with empty stage");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule
